// ===== rtl/zncc_pkg.sv =====
`default_nettype none
package zncc_pkg;

  localparam int SAMPLE_W = 8;
  localparam int WINDOW_W = 4;
  localparam int COUNT_W  = 8;
  localparam int SUM_W    = 16;
  localparam int SQSUM_W  = 24;
  localparam int OP_W     = 32;
  localparam int PROD_W   = 2 * OP_W;
  localparam int QUOT_W   = 30;
  localparam int ROOT_W   = 15;
  localparam int SCORE_W  = 16;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 4'd5;
  localparam logic [WINDOW_W-1:0] MAX_WINDOW   = 4'd15;
  localparam logic [WINDOW_W-1:0] ODD_BIT      = 4'h1;
  localparam logic [COUNT_W-1:0]  PAIRS_RESET  = 8'd25;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sd32767;

  localparam logic [4:0] DIV_STEPS  = 5'd30;
  localparam logic [4:0] SQRT_STEPS = 5'd15;

  typedef logic [3:0] step_t;

  // Steps while one item's products are folded into the sums.
  localparam step_t ACC_LL    = 4'd0;
  localparam step_t ACC_RR    = 4'd1;
  localparam step_t ACC_LR    = 4'd2;
  localparam step_t ACC_CLOSE = 4'd3;

  // Steps of the end-of-window product sequence.
  localparam step_t MUL_N_SXY    = 4'd0;
  localparam step_t MUL_SX_SY    = 4'd1;
  localparam step_t MUL_N_SXX    = 4'd2;
  localparam step_t MUL_SX_SX    = 4'd3;
  localparam step_t MUL_N_SYY    = 4'd4;
  localparam step_t MUL_SY_SY    = 4'd5;
  localparam step_t MUL_NUM_SQ   = 4'd6;
  localparam step_t MUL_VAR_PROD = 4'd7;
  localparam step_t MUL_DECIDE   = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_MUL,
    ST_ROOT,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RT_IDLE,
    RT_DIV,
    RT_SQRT,
    RT_DONE
  } root_state_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] num_sq;
    logic [PROD_W-1:0] prod;
  } root_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } root_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/zncc_if.sv =====
`default_nettype none
interface zncc_in_if;
  logic                               valid;
  logic                               ready;
  logic [zncc_pkg::SAMPLE_W-1:0]      left_sample;
  logic [zncc_pkg::SAMPLE_W-1:0]      right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface zncc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [zncc_pkg::SCORE_W-1:0] correlation;
  logic                               degenerate;

  modport source (output valid, output correlation, output degenerate, input ready);
  modport sink   (input valid, input correlation, input degenerate, output ready);
endinterface
`default_nettype wire

// ===== rtl/zncc_mul.sv =====
`default_nettype none
module zncc_mul (
  input  wire logic                          clk,
  input  wire logic [zncc_pkg::OP_W-1:0]     op_a,
  input  wire logic [zncc_pkg::OP_W-1:0]     op_b,
  output logic      [zncc_pkg::PROD_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= zncc_pkg::PROD_W'(op_a) * zncc_pkg::PROD_W'(op_b);
  end

endmodule
`default_nettype wire

// ===== rtl/zncc_root.sv =====
`default_nettype none
module zncc_root (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire zncc_pkg::root_req_t    req,
  output zncc_pkg::root_rsp_t         rsp
);

  // Computes isqrt(floor(num_sq * 2^30 / prod)) for num_sq < prod:
  // a restoring divide that produces one quotient bit a cycle, followed by
  // a digit-by-digit square root that consumes two quotient bits a cycle.

  zncc_pkg::root_state_t state_r, state_nxt;
  logic [4:0]                       cnt_r, cnt_nxt;
  logic [zncc_pkg::PROD_W:0]        rem_r, rem_nxt;
  logic [zncc_pkg::PROD_W-1:0]      div_r, div_nxt;
  logic [zncc_pkg::QUOT_W-1:0]      quot_r, quot_nxt;
  logic [zncc_pkg::ROOT_W:0]        srem_r, srem_nxt;
  logic [zncc_pkg::ROOT_W-1:0]      root_r, root_nxt;

  logic [zncc_pkg::PROD_W:0]        rem_sh;
  logic                             div_ge;
  logic [zncc_pkg::ROOT_W+2:0]      sq_sh;
  logic [zncc_pkg::ROOT_W+2:0]      sq_trial;
  logic                             sq_ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zncc_pkg::RT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    quot_r <= quot_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
  end

  always_comb begin
    rem_sh   = {rem_r[zncc_pkg::PROD_W-1:0], 1'b0};
    div_ge   = rem_sh >= {1'b0, div_r};
    sq_sh    = {srem_r, quot_r[zncc_pkg::QUOT_W-1 -: 2]};
    sq_trial = {1'b0, root_r, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    quot_nxt  = quot_r;
    srem_nxt  = srem_r;
    root_nxt  = root_r;
    rsp.done  = 1'b0;
    rsp.root  = root_r;

    unique case (state_r)
      zncc_pkg::RT_IDLE: begin
        if (req.start) begin
          rem_nxt   = {1'b0, req.num_sq};
          div_nxt   = req.prod;
          cnt_nxt   = '0;
          state_nxt = zncc_pkg::RT_DIV;
        end
      end
      zncc_pkg::RT_DIV: begin
        rem_nxt  = div_ge ? rem_sh - {1'b0, div_r} : rem_sh;
        quot_nxt = {quot_r[zncc_pkg::QUOT_W-2:0], div_ge};
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == zncc_pkg::DIV_STEPS - 5'd1) begin
          cnt_nxt   = '0;
          srem_nxt  = '0;
          root_nxt  = '0;
          state_nxt = zncc_pkg::RT_SQRT;
        end
      end
      zncc_pkg::RT_SQRT: begin
        srem_nxt = sq_ge ? (zncc_pkg::ROOT_W+1)'(sq_sh - sq_trial)
                         : (zncc_pkg::ROOT_W+1)'(sq_sh);
        root_nxt = {root_r[zncc_pkg::ROOT_W-2:0], sq_ge};
        quot_nxt = {quot_r[zncc_pkg::QUOT_W-3:0], 2'b00};
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == zncc_pkg::SQRT_STEPS - 5'd1) begin
          state_nxt = zncc_pkg::RT_DONE;
        end
      end
      zncc_pkg::RT_DONE: begin
        rsp.done  = 1'b1;
        state_nxt = zncc_pkg::RT_IDLE;
      end
      default: begin
        state_nxt = zncc_pkg::RT_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/zncc_patch_correlator.sv =====
`default_nettype none
// Channel   Direction  Handshake       Payload
// in_ch     sink       valid / ready   left_sample[7:0], right_sample[7:0]
// out_ch    source     valid / ready   correlation[15:0] signed Q1.15, degenerate
// cfg_*     write      cfg_we          cfg_wdata[3:0] = window_size (odd only)
//
// An item runs the accept cycle and then four accumulate steps that run
// three products through the shared 32x32 multiplier. The item that completes a
// window then runs nine multiplier steps, the root unit (30 divide steps,
// 15 square root steps and a done state) and a step that loads the output; a
// saturated or degenerate score skips the root unit.
// Reset (rst_n low, synchronous) clears the sums, the count and the output valid,
// and sets window_size to 5. A result waiting on out_ch does not block the
// next items; only the following window's result waits for it.
module zncc_patch_correlator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  zncc_in_if.sink                               in_ch,
  zncc_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [zncc_pkg::WINDOW_W-1:0]    cfg_wdata
);

  zncc_pkg::ctrl_state_t state_r, state_nxt;
  zncc_pkg::step_t       step_r, step_nxt;

  logic [zncc_pkg::COUNT_W-1:0]  pairs_r;
  logic [zncc_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic [zncc_pkg::SUM_W-1:0]    sum_left_r, sum_left_nxt;
  logic [zncc_pkg::SUM_W-1:0]    sum_right_r, sum_right_nxt;
  logic [zncc_pkg::SQSUM_W-1:0]  sum_left_sq_r, sum_left_sq_nxt;
  logic [zncc_pkg::SQSUM_W-1:0]  sum_right_sq_r, sum_right_sq_nxt;
  logic [zncc_pkg::SQSUM_W-1:0]  sum_cross_r, sum_cross_nxt;

  logic [zncc_pkg::SAMPLE_W-1:0] left_r, left_nxt;
  logic [zncc_pkg::SAMPLE_W-1:0] right_r, right_nxt;

  logic [zncc_pkg::OP_W-1:0]     term_r, term_nxt;
  logic [zncc_pkg::OP_W:0]       num_r, num_nxt;
  logic [zncc_pkg::OP_W:0]       var_left_r, var_left_nxt;
  logic [zncc_pkg::OP_W:0]       var_right_r, var_right_nxt;
  logic [zncc_pkg::PROD_W-1:0]   num_sq_r, num_sq_nxt;

  logic signed [zncc_pkg::SCORE_W-1:0] res_corr_r, res_corr_nxt;
  logic                                res_degen_r, res_degen_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic signed [zncc_pkg::SCORE_W-1:0] out_corr_r, out_corr_nxt;
  logic                                out_degen_r, out_degen_nxt;

  logic [zncc_pkg::OP_W-1:0]     op_a, op_b;
  logic [zncc_pkg::PROD_W-1:0]   mul_p;
  logic [zncc_pkg::OP_W:0]       num_negated;
  logic [zncc_pkg::OP_W-1:0]     num_abs;
  logic [zncc_pkg::OP_W:0]       diff;
  logic                          degen;
  logic                          num_neg;
  logic [zncc_pkg::SCORE_W-1:0]  root_ext;

  zncc_pkg::root_req_t root_req;
  zncc_pkg::root_rsp_t root_rsp;

  zncc_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (mul_p)
  );

  zncc_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (root_req),
    .rsp   (root_rsp)
  );

  // The pair count per window is kept as window_size squared.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pairs_r <= zncc_pkg::PAIRS_RESET;
    end else if (cfg_we && (cfg_wdata & zncc_pkg::ODD_BIT) != '0 &&
                 cfg_wdata <= zncc_pkg::MAX_WINDOW) begin
      pairs_r <= zncc_pkg::COUNT_W'(cfg_wdata) * zncc_pkg::COUNT_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= zncc_pkg::ST_IDLE;
      step_r         <= '0;
      count_r        <= '0;
      sum_left_r     <= '0;
      sum_right_r    <= '0;
      sum_left_sq_r  <= '0;
      sum_right_sq_r <= '0;
      sum_cross_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      step_r         <= step_nxt;
      count_r        <= count_nxt;
      sum_left_r     <= sum_left_nxt;
      sum_right_r    <= sum_right_nxt;
      sum_left_sq_r  <= sum_left_sq_nxt;
      sum_right_sq_r <= sum_right_sq_nxt;
      sum_cross_r    <= sum_cross_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    term_r      <= term_nxt;
    num_r       <= num_nxt;
    var_left_r  <= var_left_nxt;
    var_right_r <= var_right_nxt;
    num_sq_r    <= num_sq_nxt;
    res_corr_r  <= res_corr_nxt;
    res_degen_r <= res_degen_nxt;
    out_corr_r  <= out_corr_nxt;
    out_degen_r <= out_degen_nxt;
  end

  always_comb begin
    num_negated = ~num_r + 1'b1;
    num_neg     = num_r[zncc_pkg::OP_W];
    num_abs     = num_neg ? num_negated[zncc_pkg::OP_W-1:0] : num_r[zncc_pkg::OP_W-1:0];
    diff        = {1'b0, term_r} - {1'b0, mul_p[zncc_pkg::OP_W-1:0]};
    degen       = var_left_r[zncc_pkg::OP_W] || var_left_r == '0 ||
                  var_right_r[zncc_pkg::OP_W] || var_right_r == '0;
    root_ext    = {1'b0, root_rsp.root};
  end

  assign in_ch.ready        = (state_r == zncc_pkg::ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.correlation = out_corr_r;
  assign out_ch.degenerate  = out_degen_r;

  always_comb begin
    state_nxt        = state_r;
    step_nxt         = step_r;
    count_nxt        = count_r;
    sum_left_nxt     = sum_left_r;
    sum_right_nxt    = sum_right_r;
    sum_left_sq_nxt  = sum_left_sq_r;
    sum_right_sq_nxt = sum_right_sq_r;
    sum_cross_nxt    = sum_cross_r;
    left_nxt         = left_r;
    right_nxt        = right_r;
    term_nxt         = term_r;
    num_nxt          = num_r;
    var_left_nxt     = var_left_r;
    var_right_nxt    = var_right_r;
    num_sq_nxt       = num_sq_r;
    res_corr_nxt     = res_corr_r;
    res_degen_nxt    = res_degen_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_corr_nxt     = out_corr_r;
    out_degen_nxt    = out_degen_r;
    op_a             = '0;
    op_b             = '0;
    root_req.start   = 1'b0;
    root_req.num_sq  = num_sq_r;
    root_req.prod    = mul_p;

    unique case (state_r)
      zncc_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          left_nxt      = in_ch.left_sample;
          right_nxt     = in_ch.right_sample;
          sum_left_nxt  = sum_left_r + zncc_pkg::SUM_W'(in_ch.left_sample);
          sum_right_nxt = sum_right_r + zncc_pkg::SUM_W'(in_ch.right_sample);
          count_nxt     = count_r + 1'b1;
          step_nxt      = zncc_pkg::ACC_LL;
          state_nxt     = zncc_pkg::ST_ACC;
        end
      end

      // Each product lands in the multiplier register in the step after its operands
      // are presented, so each step after the first folds in the previous product.
      zncc_pkg::ST_ACC: begin
        step_nxt = step_r + 1'b1;
        case (step_r)
          zncc_pkg::ACC_LL: begin
            op_a = zncc_pkg::OP_W'(left_r);
            op_b = zncc_pkg::OP_W'(left_r);
          end
          zncc_pkg::ACC_RR: begin
            op_a            = zncc_pkg::OP_W'(right_r);
            op_b            = zncc_pkg::OP_W'(right_r);
            sum_left_sq_nxt = sum_left_sq_r + mul_p[zncc_pkg::SQSUM_W-1:0];
          end
          zncc_pkg::ACC_LR: begin
            op_a             = zncc_pkg::OP_W'(left_r);
            op_b             = zncc_pkg::OP_W'(right_r);
            sum_right_sq_nxt = sum_right_sq_r + mul_p[zncc_pkg::SQSUM_W-1:0];
          end
          default: begin
            sum_cross_nxt = sum_cross_r + mul_p[zncc_pkg::SQSUM_W-1:0];
            step_nxt      = zncc_pkg::MUL_N_SXY;
            state_nxt     = (count_r >= pairs_r) ? zncc_pkg::ST_MUL : zncc_pkg::ST_IDLE;
          end
        endcase
      end

      zncc_pkg::ST_MUL: begin
        step_nxt = step_r + 1'b1;
        case (step_r)
          zncc_pkg::MUL_N_SXY: begin
            op_a = zncc_pkg::OP_W'(pairs_r);
            op_b = zncc_pkg::OP_W'(sum_cross_r);
          end
          zncc_pkg::MUL_SX_SY: begin
            op_a     = zncc_pkg::OP_W'(sum_left_r);
            op_b     = zncc_pkg::OP_W'(sum_right_r);
            term_nxt = mul_p[zncc_pkg::OP_W-1:0];
          end
          zncc_pkg::MUL_N_SXX: begin
            op_a    = zncc_pkg::OP_W'(pairs_r);
            op_b    = zncc_pkg::OP_W'(sum_left_sq_r);
            num_nxt = diff;
          end
          zncc_pkg::MUL_SX_SX: begin
            op_a     = zncc_pkg::OP_W'(sum_left_r);
            op_b     = zncc_pkg::OP_W'(sum_left_r);
            term_nxt = mul_p[zncc_pkg::OP_W-1:0];
          end
          zncc_pkg::MUL_N_SYY: begin
            op_a         = zncc_pkg::OP_W'(pairs_r);
            op_b         = zncc_pkg::OP_W'(sum_right_sq_r);
            var_left_nxt = diff;
          end
          zncc_pkg::MUL_SY_SY: begin
            op_a     = zncc_pkg::OP_W'(sum_right_r);
            op_b     = zncc_pkg::OP_W'(sum_right_r);
            term_nxt = mul_p[zncc_pkg::OP_W-1:0];
          end
          zncc_pkg::MUL_NUM_SQ: begin
            op_a          = num_abs;
            op_b          = num_abs;
            var_right_nxt = diff;
          end
          zncc_pkg::MUL_VAR_PROD: begin
            op_a       = var_left_r[zncc_pkg::OP_W-1:0];
            op_b       = var_right_r[zncc_pkg::OP_W-1:0];
            num_sq_nxt = mul_p;
          end
          default: begin
            // The variance product is in the multiplier register now.
            count_nxt        = '0;
            sum_left_nxt     = '0;
            sum_right_nxt    = '0;
            sum_left_sq_nxt  = '0;
            sum_right_sq_nxt = '0;
            sum_cross_nxt    = '0;
            step_nxt         = '0;
            if (degen) begin
              res_corr_nxt  = '0;
              res_degen_nxt = 1'b1;
              state_nxt     = zncc_pkg::ST_EMIT;
            end else if (num_sq_r >= mul_p) begin
              // A ratio of one or more saturates.
              res_corr_nxt  = num_neg ? -zncc_pkg::SCORE_MAX : zncc_pkg::SCORE_MAX;
              res_degen_nxt = 1'b0;
              state_nxt     = zncc_pkg::ST_EMIT;
            end else begin
              root_req.start = 1'b1;
              state_nxt      = zncc_pkg::ST_ROOT;
            end
          end
        endcase
      end

      zncc_pkg::ST_ROOT: begin
        if (root_rsp.done) begin
          res_corr_nxt  = num_neg ? -$signed(root_ext) : $signed(root_ext);
          res_degen_nxt = 1'b0;
          state_nxt     = zncc_pkg::ST_EMIT;
        end
      end

      zncc_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_corr_nxt  = res_corr_r;
          out_degen_nxt = res_degen_r;
          state_nxt     = zncc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = zncc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
